// File: src/bfle_pkg.sv
// shared constants, codes and controller/datapath types for the byte fifo line extractor
`timescale 1ns / 1ps
package bfle_pkg;

  localparam int DEF_FIFO_DEPTH = 256;
  localparam int DEF_MAX_LINE   = 64;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int STS_W  = 2;
  localparam int LEN_W  = 6;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0]  CFG_LEN_RESET = 7'd64;
  localparam logic [CFG_W-1:0]  CFG_LEN_MIN   = 7'd2;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_LINE   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STS_W-1:0] ST_NO_LINE = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic              in_ready;
    logic              load;
    logic              wr_byte;
    logic              clr;
    logic              rd_cur;
    logic              rd_nxt;
    logic              pop;
    logic              hold;
    logic              len_inc;
    logic              emit_char;
    logic              emit_final;
    logic              set_code;
    logic [STS_W-1:0]  code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              in_valid;
    logic [OP_W-1:0]   op;
    logic              full;
    logic              empty;
    logic              line_none;
    logic              dout_cr;
    logic              dout_lf;
    logic              last_char;
    logic              one_left;
    logic              held_valid;
    logic              out_free;
  } sts_t;

endpackage

// File: src/bfle_if.sv
// valid/ready channel interfaces for operations in and results out
`timescale 1ns / 1ps
interface bfle_in_if;
  logic                         valid;
  logic                         ready;
  logic [bfle_pkg::OP_W-1:0]    opcode;
  logic [bfle_pkg::BYTE_W-1:0]  byte_in;

  modport source (output valid, output opcode, output byte_in, input ready);
  modport sink   (input valid, input opcode, input byte_in, output ready);
endinterface

interface bfle_out_if #(
  parameter int FILL_W = 9
);
  logic                         valid;
  logic                         ready;
  logic [bfle_pkg::STS_W-1:0]   status;
  logic [bfle_pkg::BYTE_W-1:0]  byte_out;
  logic                         byte_valid;
  logic                         last;
  logic [bfle_pkg::LEN_W-1:0]   line_length;
  logic [FILL_W-1:0]            fill_level;
  logic                         is_empty;
  logic                         is_full;
  logic                         line_pending;

  modport source (output valid, output status, output byte_out, output byte_valid,
                  output last, output line_length, output fill_level, output is_empty,
                  output is_full, output line_pending, input ready);
  modport sink   (input valid, input status, input byte_out, input byte_valid,
                  input last, input line_length, input fill_level, input is_empty,
                  input is_full, input line_pending, output ready);
endinterface

// File: src/byte_fifo_line_extractor.sv
// top level of the byte fifo line extractor: sequencer plus datapath
`timescale 1ns / 1ps
// circular byte fifo with a line reader
// in_ch carries one operation per transaction: write byte, read byte, read line,
// clear or status query (unused opcodes act as a status query). out_ch returns
// one result per transaction for every operation but read line, which returns
// one result per line character, the final one flagged by last and carrying
// line_length; every result reports fill level, empty, full and line-pending.
// cfg_we/cfg_data set the line buffer length (taken as 2..MAX_LINE); write it
// only while no operation is in flight.
// timing: the sequencer handles one operation at a time. write, clear and status
// pass from acceptance through the decide and result states, a byte read also
// through a pop state for the registered store read, a line read through the
// line pop state per byte popped (terminator included) and an lf check after a
// cr; the next operation is accepted the cycle after the final result loads.
// the single output register holds a result until out_ch.ready; while it is
// held the sequencer waits, a line read may still consume its terminator but
// pops no further character.
// reset (rst, synchronous) empties the fifo and restores a line length of 64;
// store contents are left as they are and need no clearing pass.
module byte_fifo_line_extractor #(
  parameter int FIFO_DEPTH = bfle_pkg::DEF_FIFO_DEPTH,
  parameter int MAX_LINE   = bfle_pkg::DEF_MAX_LINE
) (
  input  logic                        clk,
  input  logic                        rst,
  bfle_in_if.sink                     in_ch,
  bfle_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [bfle_pkg::CFG_W-1:0]  cfg_data
);

  // command and status bundles between sequencer and datapath
  bfle_pkg::cmd_t cmd;
  bfle_pkg::sts_t sts;

  // operation sequencer
  bfle_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // store, pointers, counters and output register
  bfle_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: src/bfle_ctrl.sv
// operation sequencer for the byte fifo line extractor
`timescale 1ns / 1ps
module bfle_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  bfle_pkg::sts_t sts,
  output bfle_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECIDE   = 6'b000010,
    S_RD_POP   = 6'b000100,
    S_LINE_POP = 6'b001000,
    S_LINE_LF  = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.code   = bfle_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESULT;
        priority if (sts.op == bfle_pkg::OP_WRITE) begin
          if (sts.full) begin
            cmd.set_code = 1'b1;
            cmd.code     = bfle_pkg::ST_FULL;
          end else begin
            cmd.wr_byte = 1'b1;
          end
        end else if (sts.op == bfle_pkg::OP_READ) begin
          if (sts.empty) begin
            cmd.set_code = 1'b1;
            cmd.code     = bfle_pkg::ST_EMPTY;
          end else begin
            cmd.rd_cur = 1'b1;
            state_next = S_RD_POP;
          end
        end else if (sts.op == bfle_pkg::OP_LINE) begin
          if (sts.line_none) begin
            cmd.set_code = 1'b1;
            cmd.code     = bfle_pkg::ST_NO_LINE;
          end else begin
            cmd.rd_cur = 1'b1;
            state_next = S_LINE_POP;
          end
        end else if (sts.op == bfle_pkg::OP_CLEAR) begin
          cmd.clr = 1'b1;
        end else begin
          // status query and unused codes: report only
        end
      end
      S_RD_POP: begin
        cmd.pop    = 1'b1;
        cmd.hold   = 1'b1;
        state_next = S_RESULT;
      end
      S_LINE_POP: begin
        priority if (sts.dout_cr) begin
          cmd.pop = 1'b1;
          if (sts.one_left) begin
            state_next = S_RESULT;
          end else begin
            cmd.rd_nxt = 1'b1;
            state_next = S_LINE_LF;
          end
        end else if (sts.dout_lf) begin
          cmd.pop    = 1'b1;
          state_next = S_RESULT;
        end else if (!sts.held_valid || sts.out_free) begin
          // previous character goes out once we know it is not the last
          cmd.pop       = 1'b1;
          cmd.hold      = 1'b1;
          cmd.len_inc   = 1'b1;
          cmd.emit_char = sts.held_valid;
          if (sts.last_char || sts.one_left) begin
            state_next = S_RESULT;
          end else begin
            cmd.rd_nxt = 1'b1;
          end
        end else begin
          // output stalled: hold everything
        end
      end
      S_LINE_LF: begin
        cmd.pop    = sts.dout_lf;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // a byte leaves the store only in the pop states
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (state == S_RD_POP || state == S_LINE_POP || state == S_LINE_LF))
    else $error("pop outside a pop state");

  // a new transaction is taken only when the previous one has fully retired
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(state == S_RESULT || state == S_IDLE))
    else $error("transaction accepted while busy");

  // a line read that reaches the lf check ends in the final result state
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LINE_LF) |=> (state == S_RESULT))
    else $error("lf check did not finish the line");

endmodule

// File: src/bfle_dp.sv
// byte store, pointers, counters, line registers and output register
`timescale 1ns / 1ps
module bfle_dp #(
  parameter int FIFO_DEPTH = bfle_pkg::DEF_FIFO_DEPTH,
  parameter int MAX_LINE   = bfle_pkg::DEF_MAX_LINE,
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  bfle_in_if.sink                     in_ch,
  bfle_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [bfle_pkg::CFG_W-1:0]  cfg_data,
  input  bfle_pkg::cmd_t              cmd,
  output bfle_pkg::sts_t              sts
);

  localparam int CMP_W = (CNT_W > bfle_pkg::LEN_W) ? CNT_W : bfle_pkg::LEN_W;
  localparam logic [bfle_pkg::CFG_W-1:0] CFG_LEN_MAX = bfle_pkg::CFG_W'(MAX_LINE);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  logic [bfle_pkg::BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [bfle_pkg::BYTE_W-1:0] dout;

  logic [bfle_pkg::CFG_W-1:0]  cfg_len;
  logic [bfle_pkg::OP_W-1:0]   op;
  logic [bfle_pkg::BYTE_W-1:0] byte_l;
  logic [PTR_W-1:0]            wptr, rptr;
  logic [CNT_W-1:0]            count, tc;
  logic [bfle_pkg::BYTE_W-1:0] held;
  logic                        held_valid;
  logic [bfle_pkg::LEN_W-1:0]  len;
  logic [bfle_pkg::STS_W-1:0]  code;

  logic                        out_valid;
  logic [bfle_pkg::STS_W-1:0]  o_status;
  logic [bfle_pkg::BYTE_W-1:0] o_byte;
  logic                        o_byte_valid, o_last;
  logic [bfle_pkg::LEN_W-1:0]  o_len;
  logic [CNT_W-1:0]            o_fill;
  logic                        o_empty, o_full, o_pending;

  logic [bfle_pkg::CFG_W-1:0]  len_clamped;
  logic [bfle_pkg::LEN_W-1:0]  win;
  logic [PTR_W-1:0]            wptr_nxt, rptr_nxt;
  logic                        out_free, dout_term, byte_term;

  assign len_clamped = (cfg_len < bfle_pkg::CFG_LEN_MIN) ? bfle_pkg::CFG_LEN_MIN :
                       (cfg_len > CFG_LEN_MAX) ? CFG_LEN_MAX : cfg_len;
  assign win       = bfle_pkg::LEN_W'(len_clamped - 1'b1);
  assign wptr_nxt  = (wptr == PTR_LAST) ? '0 : wptr + 1'b1;
  assign rptr_nxt  = (rptr == PTR_LAST) ? '0 : rptr + 1'b1;
  assign out_free  = !out_valid || out_ch.ready;
  assign dout_term = (dout == bfle_pkg::CH_CR) || (dout == bfle_pkg::CH_LF);
  assign byte_term = (byte_l == bfle_pkg::CH_CR) || (byte_l == bfle_pkg::CH_LF);

  always_comb begin
    sts.in_valid   = in_ch.valid;
    sts.op         = op;
    sts.full       = (count == CNT_FULL);
    sts.empty      = (count == '0);
    sts.line_none  = (CMP_W'(count) < CMP_W'(win)) && (tc == '0);
    sts.dout_cr    = (dout == bfle_pkg::CH_CR);
    sts.dout_lf    = (dout == bfle_pkg::CH_LF);
    sts.last_char  = ((len + 1'b1) == win);
    sts.one_left   = (count == CNT_W'(1));
    sts.held_valid = held_valid;
    sts.out_free   = out_free;
  end

  assign in_ch.ready = cmd.in_ready;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[wptr] <= byte_l;
    end
    if (cmd.rd_cur || cmd.rd_nxt) begin
      dout <= mem[cmd.rd_nxt ? rptr_nxt : rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len <= bfle_pkg::CFG_LEN_RESET;
    end else if (cfg_we) begin
      cfg_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
      tc    <= '0;
    end else begin
      priority if (cmd.clr) begin
        wptr  <= '0;
        rptr  <= '0;
        count <= '0;
        tc    <= '0;
      end else if (cmd.wr_byte) begin
        wptr  <= wptr_nxt;
        count <= count + 1'b1;
        if (byte_term) begin
          tc <= tc + 1'b1;
        end
      end else if (cmd.pop) begin
        rptr  <= rptr_nxt;
        count <= count - 1'b1;
        if (dout_term && (tc != '0)) begin
          tc <= tc - 1'b1;
        end
      end else begin
        // no change
      end
    end
  end

  // per-transaction registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.load) begin
      held_valid <= 1'b0;
    end else if (cmd.hold) begin
      held_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_ch.opcode;
      byte_l <= in_ch.byte_in;
      held   <= '0;
      len    <= '0;
      code   <= bfle_pkg::ST_OK;
    end else begin
      if (cmd.hold) begin
        held <= dout;
      end
      if (cmd.len_inc) begin
        len <= len + 1'b1;
      end
      if (cmd.set_code) begin
        code <= cmd.code;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_char || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char || cmd.emit_final) begin
      o_status     <= cmd.emit_final ? code : bfle_pkg::ST_OK;
      o_byte       <= held;
      o_byte_valid <= cmd.emit_final ? held_valid : 1'b1;
      o_last       <= cmd.emit_final;
      o_len        <= cmd.emit_final ? len : '0;
      o_fill       <= count;
      o_empty      <= (count == '0);
      o_full       <= (count == CNT_FULL);
      o_pending    <= (tc != '0);
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = o_status;
  assign out_ch.byte_out     = o_byte;
  assign out_ch.byte_valid   = o_byte_valid;
  assign out_ch.last         = o_last;
  assign out_ch.line_length  = o_len;
  assign out_ch.fill_level   = o_fill;
  assign out_ch.is_empty     = o_empty;
  assign out_ch.is_full      = o_full;
  assign out_ch.line_pending = o_pending;

  assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("fill count above depth");

  assert property (@(posedge clk) disable iff (rst) tc <= count)
    else $error("terminator count above fill count");

  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_FULL) |-> (rptr == wptr))
    else $error("pointers disagree with fill count");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_char || cmd.emit_final) |-> out_free)
    else $error("result written over a waiting result");

endmodule

// File: bench/byte_fifo_line_extractor_tb.sv
// self-checking bench for the byte fifo line extractor: scoreboard, stimulus and flow control
`timescale 1ns / 1ps
module byte_fifo_line_extractor_tb;

  localparam int DEPTH         = bfle_pkg::DEF_FIFO_DEPTH;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_CYCLES  = 2000000;
  localparam int PHASE_ITEMS   = 8;

  // opcodes with no operation of their own, they behave as a status query
  localparam logic [bfle_pkg::OP_W-1:0] OP_SPARE_LO = bfle_pkg::OP_STATUS + 3'd1;
  localparam logic [bfle_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  // one result transaction as seen on out_ch
  typedef struct packed {
    logic [bfle_pkg::STS_W-1:0]  status;
    logic [bfle_pkg::BYTE_W-1:0] byte_out;
    logic                        byte_valid;
    logic                        last;
    logic [bfle_pkg::LEN_W-1:0]  line_length;
    logic [8:0]                  fill_level;
    logic                        is_empty;
    logic                        is_full;
    logic                        line_pending;
  } line_result_t;

  // shadow copy of the fifo plus the queue of results it predicts
  class line_fifo_scoreboard;
    logic [bfle_pkg::BYTE_W-1:0] store [DEPTH];
    int unsigned                 wr_ptr;
    int unsigned                 rd_ptr;
    int unsigned                 fill;
    int unsigned                 eol_count;
    logic [bfle_pkg::CFG_W-1:0]  line_len_cfg;
    line_result_t                expected_results [$];
    int unsigned                 mismatches;

    function new();
      wr_ptr       = 0;
      rd_ptr       = 0;
      fill         = 0;
      eol_count    = 0;
      line_len_cfg = bfle_pkg::CFG_LEN_RESET;
      mismatches   = 0;
    endfunction

    function void set_line_len(logic [bfle_pkg::CFG_W-1:0] v);
      line_len_cfg = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // characters a line may hold under the current setting
    function int unsigned window();
      int unsigned lim;
      lim = 32'(line_len_cfg);
      if (lim < 32'(bfle_pkg::CFG_LEN_MIN)) lim = 32'(bfle_pkg::CFG_LEN_MIN);
      if (lim > bfle_pkg::DEF_MAX_LINE) lim = bfle_pkg::DEF_MAX_LINE;
      return lim - 1;
    endfunction

    function bit is_eol(logic [bfle_pkg::BYTE_W-1:0] c);
      return (c == bfle_pkg::CH_CR) || (c == bfle_pkg::CH_LF);
    endfunction

    function logic [bfle_pkg::BYTE_W-1:0] pop_byte();
      logic [bfle_pkg::BYTE_W-1:0] c;
      c      = store[rd_ptr];
      rd_ptr = (rd_ptr + 1) % DEPTH;
      fill--;
      if (is_eol(c) && eol_count > 0) eol_count--;
      return c;
    endfunction

    function line_result_t make_result(logic [bfle_pkg::STS_W-1:0] st,
                                       logic [bfle_pkg::BYTE_W-1:0] b,
                                       logic bv, logic lst,
                                       logic [bfle_pkg::LEN_W-1:0] len);
      line_result_t r;
      r.status       = st;
      r.byte_out     = b;
      r.byte_valid   = bv;
      r.last         = lst;
      r.line_length  = len;
      r.fill_level   = fill[8:0];
      r.is_empty     = (fill == 0);
      r.is_full      = (fill >= DEPTH);
      r.line_pending = (eol_count != 0);
      return r;
    endfunction

    // line read: scan the window, then pop characters up to the terminator
    function void apply_line_read();
      int unsigned                 win;
      int unsigned                 len;
      bit                          found;
      logic [bfle_pkg::BYTE_W-1:0] c;
      line_result_t                r;
      win   = window();
      len   = 0;
      found = 0;
      for (int unsigned i = 0; i < win && i < fill; i++) begin
        if (is_eol(store[(rd_ptr + i) % DEPTH])) begin
          found = 1;
          break;
        end
      end
      // no terminator and too few bytes for a truncated line: nothing consumed
      if (!found && fill < win) begin
        expected_results.push_back(make_result(bfle_pkg::ST_NO_LINE, 8'h00, 1'b0, 1'b1, '0));
        return;
      end
      while (len < win && fill > 0) begin
        c = pop_byte();
        if (c == bfle_pkg::CH_CR) begin
          // an lf right behind a cr belongs to the same terminator
          if (fill > 0 && store[rd_ptr] == bfle_pkg::CH_LF) void'(pop_byte());
          break;
        end
        if (c == bfle_pkg::CH_LF) break;
        expected_results.push_back(make_result(bfle_pkg::ST_OK, c, 1'b1, 1'b0, '0));
        len++;
      end
      if (len == 0) begin
        // empty line
        expected_results.push_back(make_result(bfle_pkg::ST_OK, 8'h00, 1'b0, 1'b1, '0));
        return;
      end
      // final character carries the length and the fill after the terminator
      r = expected_results.pop_back();
      expected_results.push_back(make_result(bfle_pkg::ST_OK, r.byte_out, 1'b1, 1'b1,
                                             len[bfle_pkg::LEN_W-1:0]));
    endfunction

    // note one accepted operation and queue the results it causes
    function void apply_op(logic [bfle_pkg::OP_W-1:0] op, logic [bfle_pkg::BYTE_W-1:0] b);
      logic [bfle_pkg::BYTE_W-1:0] c;
      case (op)
        bfle_pkg::OP_WRITE: begin
          if (fill >= DEPTH) begin
            expected_results.push_back(make_result(bfle_pkg::ST_FULL, 8'h00, 1'b0, 1'b1, '0));
          end else begin
            store[wr_ptr] = b;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
            if (is_eol(b)) eol_count++;
            expected_results.push_back(make_result(bfle_pkg::ST_OK, 8'h00, 1'b0, 1'b1, '0));
          end
        end
        bfle_pkg::OP_READ: begin
          if (fill == 0) begin
            expected_results.push_back(make_result(bfle_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1,
                                                   '0));
          end else begin
            c = pop_byte();
            expected_results.push_back(make_result(bfle_pkg::ST_OK, c, 1'b1, 1'b1, '0));
          end
        end
        bfle_pkg::OP_LINE: apply_line_read();
        bfle_pkg::OP_CLEAR: begin
          wr_ptr    = 0;
          rd_ptr    = 0;
          fill      = 0;
          eol_count = 0;
          expected_results.push_back(make_result(bfle_pkg::ST_OK, 8'h00, 1'b0, 1'b1, '0));
        end
        default: expected_results.push_back(make_result(bfle_pkg::ST_OK, 8'h00, 1'b0, 1'b1,
                                                        '0));
      endcase
    endfunction

    task report(string what, logic [8:0] got, logic [8:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(line_result_t got);
      line_result_t exp;
      if (expected_results.size() == 0) begin
        report("unexpected result, status", 9'(got.status), '0);
        return;
      end
      exp = expected_results.pop_front();
      if (got.status !== exp.status)
        report("status", 9'(got.status), 9'(exp.status));
      if (got.byte_out !== exp.byte_out)
        report("byte_out", 9'(got.byte_out), 9'(exp.byte_out));
      if (got.byte_valid !== exp.byte_valid)
        report("byte_valid", 9'(got.byte_valid), 9'(exp.byte_valid));
      if (got.last !== exp.last) report("last", 9'(got.last), 9'(exp.last));
      if (got.line_length !== exp.line_length)
        report("line_length", 9'(got.line_length), 9'(exp.line_length));
      if (got.fill_level !== exp.fill_level)
        report("fill_level", got.fill_level, exp.fill_level);
      if (got.is_empty !== exp.is_empty)
        report("is_empty", 9'(got.is_empty), 9'(exp.is_empty));
      if (got.is_full !== exp.is_full)
        report("is_full", 9'(got.is_full), 9'(exp.is_full));
      if (got.line_pending !== exp.line_pending)
        report("line_pending", 9'(got.line_pending), 9'(exp.line_pending));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [bfle_pkg::CFG_W-1:0] cfg_data;

  bfle_in_if             in_ch ();
  bfle_out_if #(.FILL_W(9)) out_ch ();

  byte_fifo_line_extractor #(
    .FIFO_DEPTH (DEPTH),
    .MAX_LINE   (bfle_pkg::DEF_MAX_LINE)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  line_fifo_scoreboard sb;
  int unsigned         items_sent;
  int unsigned         burst_left;
  int unsigned         cycle_count = 0;
  bit                  hold_req;

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung handshake or a missing result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // every accepted result transaction goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    line_result_t got;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.status       = out_ch.status;
      got.byte_out     = out_ch.byte_out;
      got.byte_valid   = out_ch.byte_valid;
      got.last         = out_ch.last;
      got.line_length  = out_ch.line_length;
      got.fill_level   = out_ch.fill_level;
      got.is_empty     = out_ch.is_empty;
      got.is_full      = out_ch.is_full;
      got.line_pending = out_ch.line_pending;
      sb.check_result(got);
    end
  end

  // receiver: stretches of always-ready, random ready, and short stalls; on request
  // one long hold-off so that the single output register backs up into the input
  initial begin : receiver
    int mode;
    int span;
    bit hold_done;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 24);
        repeat (span) begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       out_ch.ready <= 1'($urandom_range(0, 1));
            default: out_ch.ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // offer one operation and hold it until the transaction completes; the sender
  // works in bursts, and a random gap with valid low follows the end of each one
  task automatic send_op(logic [bfle_pkg::OP_W-1:0] op, logic [bfle_pkg::BYTE_W-1:0] data);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.byte_in <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.apply_op(op, data);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait for every outstanding result, then let the sequencer go idle
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write only while nothing is in flight
  task automatic write_line_len(logic [bfle_pkg::CFG_W-1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_line_len(v);
  endtask

  function automatic logic [bfle_pkg::BYTE_W-1:0] plain_char();
    logic [bfle_pkg::BYTE_W-1:0] c;
    do c = bfle_pkg::BYTE_W'($urandom_range(0, 255));
    while (c == bfle_pkg::CH_CR || c == bfle_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [bfle_pkg::BYTE_W-1:0] any_byte();
    return bfle_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // a text line with random content and one of several endings, then line reads
  task automatic send_text_line();
    int unsigned win;
    int unsigned nchar;
    int          ending;
    win   = sb.window();
    nchar = ($urandom_range(0, 3) == 0) ? $urandom_range(0, win + 2) : $urandom_range(0, win - 1);
    repeat (nchar) send_op(bfle_pkg::OP_WRITE, plain_char());
    ending = $urandom_range(0, 5);
    case (ending)
      0: send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
      1: send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
      2: begin
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
      end
      3: ; // unterminated: either no line yet or a truncated one
      4: begin
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
      end
      default: begin
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
        send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
      end
    endcase
    repeat ($urandom_range(1, 2)) send_op(bfle_pkg::OP_LINE, any_byte());
  endtask

  task automatic send_noise();
    logic [bfle_pkg::BYTE_W-1:0] b;
    if ($urandom_range(0, 3) == 0) b = $urandom_range(0, 1) ? bfle_pkg::CH_CR : bfle_pkg::CH_LF;
    else b = any_byte();
    send_op(bfle_pkg::OP_W'($urandom_range(bfle_pkg::OP_WRITE, OP_SPARE_HI)), b);
  endtask

  // settings visited by the random phases: below the minimum, top of the field,
  // smallest legal, reset value, and a few in between
  logic [bfle_pkg::CFG_W-1:0] len_plan [8] = '{7'd0, 7'd127, 7'd3, 7'd1, 7'd64, 7'd2, 7'd9,
                                               7'd100};

  initial begin : stimulus
    int unsigned phase_end;
    int          pick;
    sb            = new();
    items_sent    = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = bfle_pkg::CFG_LEN_RESET;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = bfle_pkg::OP_STATUS;
    in_ch.byte_in = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: queries and reads on an empty fifo
    send_op(bfle_pkg::OP_STATUS, 8'h00);
    for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) send_op(k[bfle_pkg::OP_W-1:0], 8'hFF);
    send_op(bfle_pkg::OP_READ, 8'h00);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    // one byte with no terminator: no line yet
    send_op(bfle_pkg::OP_WRITE, 8'h61);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    // cr as the last stored byte, nothing to swallow
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    // cr lf pair gives an empty line, byte extremes go through byte and line reads
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
    send_op(bfle_pkg::OP_WRITE, 8'h00);
    send_op(bfle_pkg::OP_WRITE, 8'hFF);
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    send_op(bfle_pkg::OP_READ, 8'h00);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    // cr followed by an ordinary byte is not swallowed
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_CR);
    send_op(bfle_pkg::OP_WRITE, 8'h62);
    send_op(bfle_pkg::OP_WRITE, bfle_pkg::CH_LF);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    send_op(bfle_pkg::OP_LINE, 8'h00);
    // clear with data stored
    send_op(bfle_pkg::OP_WRITE, 8'h55);
    send_op(bfle_pkg::OP_CLEAR, 8'h00);
    send_op(bfle_pkg::OP_STATUS, 8'h00);

    // random phases, one line length setting each
    for (int p = 0; p < 8; p++) begin
      write_line_len(len_plan[p]);
      if (p == 2) hold_req = 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (sb.fill > 200) send_op(bfle_pkg::OP_CLEAR, any_byte());
        pick = $urandom_range(0, 99);
        if (pick < 55) send_text_line();
        else if (pick < 65) repeat ($urandom_range(1, 3)) send_op(bfle_pkg::OP_READ, any_byte());
        else if (pick < 72)
          send_op(bfle_pkg::OP_W'($urandom_range(bfle_pkg::OP_STATUS, OP_SPARE_HI)), any_byte());
        else if (pick < 76) send_op(bfle_pkg::OP_CLEAR, any_byte());
        else if (pick < 80) send_op(bfle_pkg::OP_LINE, any_byte());
        else send_noise();
      end
    end

    // fill to the top from wherever the pointers stand, overflow, then drain by lines and bytes
    write_line_len(bfle_pkg::CFG_LEN_RESET);
    while (sb.fill < DEPTH)
      send_op(bfle_pkg::OP_WRITE, ($urandom_range(0, 19) == 0) ? bfle_pkg::CH_CR : plain_char());
    repeat (3) send_op(bfle_pkg::OP_WRITE, any_byte());
    send_op(bfle_pkg::OP_STATUS, any_byte());
    while (sb.fill >= sb.window() || sb.eol_count != 0) send_op(bfle_pkg::OP_LINE, any_byte());
    while (sb.fill != 0) send_op(bfle_pkg::OP_READ, any_byte());
    send_op(bfle_pkg::OP_READ, any_byte());

    // drain and give a stray result time to show up
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
